### sv/tbc_pkg.sv
package tbc_pkg;

   localparam int unsigned WORD_W     = 32;
   localparam int unsigned NUM_ROUNDS = 32;
   localparam logic [WORD_W-1:0] TEA_DELTA = 32'hb979379e;

   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W  = WORD_W;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY_WORD_ZERO  = 8'd0,
      CSR_KEY_WORD_ONE   = 8'd1,
      CSR_KEY_WORD_TWO   = 8'd2,
      CSR_KEY_WORD_THREE = 8'd3
   } csr_index_type;

   localparam logic KIND_ENCRYPT = 1'b0;
   localparam logic KIND_DECRYPT = 1'b1;

   typedef struct packed {
      logic [WORD_W-1:0] k0;
      logic [WORD_W-1:0] k1;
      logic [WORD_W-1:0] k2;
      logic [WORD_W-1:0] k3;
   } key_set_type;

   typedef struct packed {
      logic              kind;
      logic [WORD_W-1:0] w0;
      logic [WORD_W-1:0] w1;
      logic              last;
   } stage_data_type;

   // Running sum after n additions of the round constant, modulo 2^32.
   function automatic logic [WORD_W-1:0] tea_sum(input int unsigned n);
      logic [2*WORD_W-1:0] prod;
      prod = (2*WORD_W)'(n) * (2*WORD_W)'(TEA_DELTA);
      return prod[WORD_W-1:0];
   endfunction

endpackage

### sv/tbc_req_if.sv
interface tbc_req_if;
   import tbc_pkg::*;

   logic              valid;
   logic              ready;
   logic              kind;
   logic [WORD_W-1:0] block_first_word;
   logic [WORD_W-1:0] block_second_word;
   logic              last_block;

   modport source (
      output valid, kind, block_first_word, block_second_word, last_block,
      input  ready
   );
   modport sink (
      input  valid, kind, block_first_word, block_second_word, last_block,
      output ready
   );
endinterface

### sv/tbc_rsp_if.sv
interface tbc_rsp_if;
   import tbc_pkg::*;

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] result_first_word;
   logic [WORD_W-1:0] result_second_word;
   logic              result_last;

   modport source (
      output valid, result_first_word, result_second_word, result_last,
      input  ready
   );
   modport sink (
      input  valid, result_first_word, result_second_word, result_last,
      output ready
   );
endinterface

### sv/tbc_key_regs.sv
module tbc_key_regs
   import tbc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output key_set_type            keys
);

   key_set_type keys_ff;
   key_set_type keys_in;

   always_comb begin
      keys_in = keys_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_KEY_WORD_ZERO:  keys_in.k0 = csr_wdata[WORD_W-1:0];
            CSR_KEY_WORD_ONE:   keys_in.k1 = csr_wdata[WORD_W-1:0];
            CSR_KEY_WORD_TWO:   keys_in.k2 = csr_wdata[WORD_W-1:0];
            CSR_KEY_WORD_THREE: keys_in.k3 = csr_wdata[WORD_W-1:0];
            default:            keys_in = keys_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ff <= '0;
      end else begin
         keys_ff <= keys_in;
      end
   end

   assign keys = keys_ff;

endmodule

### sv/tbc_half_round.sv
module tbc_half_round
   import tbc_pkg::*;
#(
   parameter int unsigned ROUNDS = NUM_ROUNDS,
   parameter int unsigned STAGE  = 0
) (
   input  logic           clock,
   input  logic           reset,
   input  key_set_type    keys,
   input  logic           in_valid,
   output logic           in_ready,
   input  stage_data_type in_data,
   output logic           out_valid,
   input  logic           out_ready,
   output stage_data_type out_data
);

   // Encryption round r uses (r+1) deltas; decryption round r uses (ROUNDS-r).
   localparam logic [WORD_W-1:0] ENC_SUM = tea_sum(STAGE / 2 + 1);
   localparam logic [WORD_W-1:0] DEC_SUM = tea_sum(ROUNDS - STAGE / 2);
   localparam logic FIRST_HALF = ((STAGE % 2) == 0);

   function automatic logic [WORD_W-1:0] mix_half(
      input logic [WORD_W-1:0] v,
      input logic [WORD_W-1:0] sum,
      input logic [WORD_W-1:0] ka,
      input logic [WORD_W-1:0] kb
   );
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] c;
      a = (v << 4) + ka;
      b = v + sum;
      c = (v >> 5) + kb;
      return a ^ b ^ c;
   endfunction

   logic              valid_ff;
   stage_data_type    data_ff;
   stage_data_type    data_in;
   logic              upd_w0;
   logic [WORD_W-1:0] sum;
   logic [WORD_W-1:0] src;
   logic [WORD_W-1:0] dst;
   logic [WORD_W-1:0] ka;
   logic [WORD_W-1:0] kb;
   logic [WORD_W-1:0] mix;
   logic [WORD_W-1:0] upd;

   // Encryption updates the first word in the first half and the second word
   // in the second half; decryption runs the two halves in the opposite order.
   always_comb begin
      upd_w0 = FIRST_HALF ^ (in_data.kind == KIND_DECRYPT);
      sum    = (in_data.kind == KIND_DECRYPT) ? DEC_SUM : ENC_SUM;
      src    = upd_w0 ? in_data.w1 : in_data.w0;
      dst    = upd_w0 ? in_data.w0 : in_data.w1;
      ka     = upd_w0 ? keys.k0 : keys.k2;
      kb     = upd_w0 ? keys.k1 : keys.k3;
      mix    = mix_half(src, sum, ka, kb);
      upd    = (in_data.kind == KIND_DECRYPT) ? (dst - mix) : (dst + mix);
      data_in = in_data;
      if (upd_w0) begin
         data_in.w0 = upd;
      end else begin
         data_in.w1 = upd;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### sv/tea_block_cipher_top.sv
// TEA block cipher, ECB, with round constant 0xb979379e. Each request carries
// one 64-bit block as two little-endian words, a mode bit (0 encrypt,
// 1 decrypt) and a last-block flag that comes back unchanged. The Feistel
// network is unrolled into 2*ROUNDS register stages, one half-round each, and
// one block can enter every cycle while the output is not stalled. Each stage
// holds its data while the next one is stalled, and a stage with a free slot
// keeps taking requests, so the last stage serves as the output register. The
// four key words are set through the csr port at indexes 0 to 3; other indexes
// are ignored. Change the key only while no block is in flight.
module tea_block_cipher_top
   import tbc_pkg::*;
#(
   parameter int unsigned ROUNDS = NUM_ROUNDS
) (
   input  logic                   clock,
   input  logic                   reset,
   tbc_req_if.sink                req_if,
   tbc_rsp_if.source              rsp_if,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int unsigned NUM_STAGES = 2 * ROUNDS;

   key_set_type    keys;
   logic           valid [NUM_STAGES+1];
   logic           ready [NUM_STAGES+1];
   stage_data_type data  [NUM_STAGES+1];

   tbc_key_regs u_key_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .keys      (keys)
   );

   assign valid[0]      = req_if.valid;
   assign req_if.ready  = ready[0];
   assign data[0].kind  = req_if.kind;
   assign data[0].w0    = req_if.block_first_word;
   assign data[0].w1    = req_if.block_second_word;
   assign data[0].last  = req_if.last_block;

   for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
      tbc_half_round #(
         .ROUNDS (ROUNDS),
         .STAGE  (s)
      ) u_half_round (
         .clock     (clock),
         .reset     (reset),
         .keys      (keys),
         .in_valid  (valid[s]),
         .in_ready  (ready[s]),
         .in_data   (data[s]),
         .out_valid (valid[s+1]),
         .out_ready (ready[s+1]),
         .out_data  (data[s+1])
      );
   end

   assign rsp_if.valid              = valid[NUM_STAGES];
   assign ready[NUM_STAGES]         = rsp_if.ready;
   assign rsp_if.result_first_word  = data[NUM_STAGES].w0;
   assign rsp_if.result_second_word = data[NUM_STAGES].w1;
   assign rsp_if.result_last        = data[NUM_STAGES].last;

endmodule

### dv/tb_tea_block_cipher_top.sv
`timescale 1ns / 1ps

module tb_tea_block_cipher_top;
   import tbc_pkg::*;

   localparam int unsigned HALF_PERIOD     = 10;
   localparam int unsigned PIPE_LATENCY    = 2 * NUM_ROUNDS;
   localparam int unsigned ITEMS_PER_KEY   = 295;
   localparam int unsigned KEY_SETTINGS    = 6;
   localparam int unsigned STEADY_SETTING  = 2;
   localparam int unsigned HOLD_SETTING    = 3;
   localparam int unsigned PAUSE_SETTING   = 4;
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   localparam int unsigned IDLE_PERCENT    = 21;
   localparam int unsigned RUN_LIMIT_NS    = 10_000_000;
   localparam int unsigned DIRECTED_COUNT  = 12;

   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_FIRST_UNUSED = 8'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_LAST_UNUSED  = 8'hff;

   typedef struct packed {
      logic              kind;
      logic [WORD_W-1:0] w0;
      logic [WORD_W-1:0] w1;
      logic              last;
   } block_request_type;

   typedef struct packed {
      logic [WORD_W-1:0] w0;
      logic [WORD_W-1:0] w1;
      logic              last;
   } block_result_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   tbc_req_if req_ch ();
   tbc_rsp_if rsp_ch ();

   key_set_type      key_copy;
   block_result_type expected_blocks[$];
   int unsigned      error_count;
   int unsigned      checked_count;
   int unsigned      encrypt_count;
   int unsigned      decrypt_count;
   int unsigned      last_count;
   int unsigned      blocks_sent;
   bit               steady_stream;
   int unsigned      hold_off_request;

   // Corner blocks, all checked against the cipher model below.
   block_request_type directed_rows [DIRECTED_COUNT] = '{
      '{KIND_ENCRYPT, 32'h0000_0000, 32'h0000_0000, 1'b0},
      '{KIND_DECRYPT, 32'h0000_0000, 32'h0000_0000, 1'b1},
      '{KIND_ENCRYPT, 32'hffff_ffff, 32'hffff_ffff, 1'b1},
      '{KIND_DECRYPT, 32'hffff_ffff, 32'hffff_ffff, 1'b0},
      '{KIND_ENCRYPT, 32'h8000_0000, 32'h0000_0001, 1'b0},
      '{KIND_DECRYPT, 32'h8000_0000, 32'h0000_0001, 1'b1},
      '{KIND_ENCRYPT, 32'h0000_0001, 32'h8000_0000, 1'b1},
      '{KIND_DECRYPT, 32'h7fff_ffff, 32'hffff_fffe, 1'b0},
      '{KIND_ENCRYPT, 32'haaaa_aaaa, 32'h5555_5555, 1'b0},
      '{KIND_DECRYPT, 32'h5555_5555, 32'haaaa_aaaa, 1'b1},
      '{KIND_ENCRYPT, 32'h0123_4567, 32'h89ab_cdef, 1'b1},
      '{KIND_DECRYPT, 32'hfedc_ba98, 32'h7654_3210, 1'b0}
   };

   tea_block_cipher_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   function automatic logic [WORD_W-1:0] tea_mix(input logic [WORD_W-1:0] v,
                                                 input logic [WORD_W-1:0] sum,
                                                 input logic [WORD_W-1:0] ka,
                                                 input logic [WORD_W-1:0] kb);
      return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
   endfunction

   function automatic block_result_type tea_cipher(input block_request_type blk);
      logic [WORD_W-1:0] v0;
      logic [WORD_W-1:0] v1;
      logic [WORD_W-1:0] sum;
      block_result_type  res;
      v0  = blk.w0;
      v1  = blk.w1;
      sum = '0;
      if (blk.kind == KIND_ENCRYPT) begin
         for (int r = 0; r < NUM_ROUNDS; r++) begin
            sum = sum + TEA_DELTA;
            v0  = v0 + tea_mix(v1, sum, key_copy.k0, key_copy.k1);
            v1  = v1 + tea_mix(v0, sum, key_copy.k2, key_copy.k3);
         end
      end else begin
         // Decryption starts from the sum of the last encryption round.
         for (int r = 0; r < NUM_ROUNDS; r++) sum = sum + TEA_DELTA;
         for (int r = 0; r < NUM_ROUNDS; r++) begin
            v1  = v1 - tea_mix(v0, sum, key_copy.k2, key_copy.k3);
            v0  = v0 - tea_mix(v1, sum, key_copy.k0, key_copy.k1);
            sum = sum - TEA_DELTA;
         end
      end
      res.w0   = v0;
      res.w1   = v1;
      res.last = blk.last;
      return res;
   endfunction

   function automatic bit take_idle();
      return !steady_stream && ($urandom_range(0, 99) < IDLE_PERCENT);
   endfunction

   function automatic logic [WORD_W-1:0] pick_word();
      logic [WORD_W-1:0] one_hot;
      one_hot = 32'h1 << $urandom_range(0, WORD_W - 1);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return one_hot;
         3: return ~one_hot;
         default: return $urandom;
      endcase
   endfunction

   function automatic key_set_type key_for_setting(input int unsigned setting);
      key_set_type k;
      case (setting)
         0: k = '1;
         1: begin
            k.k0 = 32'h8000_0000;
            k.k1 = 32'h0000_0001;
            k.k2 = 32'h7fff_ffff;
            k.k3 = 32'hffff_fffe;
         end
         KEY_SETTINGS - 1: k = '0;
         default: begin
            k.k0 = $urandom;
            k.k1 = $urandom;
            k.k2 = $urandom;
            k.k3 = $urandom;
         end
      endcase
      return k;
   endfunction

   function automatic void compare_field(input string field, input logic [WORD_W-1:0] want,
                                         input logic [WORD_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         error_count++;
      end
   endfunction

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      case (index)
         CSR_KEY_WORD_ZERO:  key_copy.k0 = data;
         CSR_KEY_WORD_ONE:   key_copy.k1 = data;
         CSR_KEY_WORD_TWO:   key_copy.k2 = data;
         CSR_KEY_WORD_THREE: key_copy.k3 = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic load_key(input key_set_type k);
      write_csr(CSR_KEY_WORD_ZERO, k.k0);
      write_csr(CSR_KEY_WORD_ONE, k.k1);
      write_csr(CSR_KEY_WORD_TWO, k.k2);
      write_csr(CSR_KEY_WORD_THREE, k.k3);
      csr_we <= 1'b0;
   endtask

   task automatic send_block(input block_request_type blk);
      while (take_idle()) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid             <= 1'b1;
      req_ch.kind              <= blk.kind;
      req_ch.block_first_word  <= blk.w0;
      req_ch.block_second_word <= blk.w1;
      req_ch.last_block        <= blk.last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      blocks_sent++;
   endtask

   // A message is a run of blocks with one mode and the last flag on its final
   // block; a few blocks flip the mode or the flag to break the framing.
   task automatic send_message();
      int unsigned       length;
      logic              kind;
      block_request_type blk;
      length = $urandom_range(1, 8);
      kind   = 1'($urandom_range(0, 1));
      for (int unsigned i = 0; i < length; i++) begin
         blk.kind = ($urandom_range(0, 9) == 0) ? ~kind : kind;
         blk.w0   = pick_word();
         blk.w1   = pick_word();
         blk.last = (i == length - 1);
         if ($urandom_range(0, 19) == 0) blk.last = ~blk.last;
         send_block(blk);
      end
   endtask

   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (expected_blocks.size() != 0);
   endtask

   always @(posedge clock) begin : request_monitor
      block_request_type blk;
      if (!reset && req_ch.valid && req_ch.ready) begin
         blk.kind = req_ch.kind;
         blk.w0   = req_ch.block_first_word;
         blk.w1   = req_ch.block_second_word;
         blk.last = req_ch.last_block;
         expected_blocks.push_back(tea_cipher(blk));
         if (blk.kind == KIND_ENCRYPT) encrypt_count++;
         else decrypt_count++;
         if (blk.last) last_count++;
      end
   end

   always @(posedge clock) begin : result_check
      block_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_blocks.size() == 0) begin
            $display("%0t: result with nothing expected, actual %h %h last %b", $time,
                     rsp_ch.result_first_word, rsp_ch.result_second_word,
                     rsp_ch.result_last);
            error_count++;
         end else begin
            want = expected_blocks.pop_front();
            checked_count++;
            compare_field("first word", want.w0, rsp_ch.result_first_word);
            compare_field("second word", want.w1, rsp_ch.result_second_word);
            compare_field("last flag", 32'(want.last), 32'(rsp_ch.result_last));
         end
      end
   end

   // The output side; a requested hold-off is counted down here.
   initial begin : result_sink
      int unsigned hold_left;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request != 0) begin
            hold_left        = hold_off_request;
            hold_off_request = 0;
         end
         if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= !take_idle();
         end
      end
   end

   initial begin : stimulus
      int unsigned phase_start;
      bit          paused;
      error_count      = 0;
      checked_count    = 0;
      encrypt_count    = 0;
      decrypt_count    = 0;
      last_count       = 0;
      blocks_sent      = 0;
      steady_stream    = 1'b0;
      hold_off_request = 0;
      paused           = 1'b0;
      key_copy         = '0;
      reset                    <= 1'b1;
      csr_we                   <= 1'b0;
      csr_index                <= '0;
      csr_wdata                <= '0;
      req_ch.valid             <= 1'b0;
      req_ch.kind              <= KIND_ENCRYPT;
      req_ch.block_first_word  <= '0;
      req_ch.block_second_word <= '0;
      req_ch.last_block        <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_block(directed_rows[i]);
      wait_for_results();

      // Writes outside the key range must leave the key untouched.
      write_csr(CSR_INDEX_FIRST_UNUSED, 32'h5a5a_a5a5);
      write_csr(CSR_INDEX_LAST_UNUSED, 32'hffff_ffff);
      csr_we <= 1'b0;
      repeat (2) send_message();
      wait_for_results();

      for (int unsigned setting = 0; setting < KEY_SETTINGS; setting++) begin
         load_key(key_for_setting(setting));
         steady_stream = (setting == STEADY_SETTING);
         if (setting == HOLD_SETTING) hold_off_request = HOLD_OFF_CYCLES;
         phase_start = blocks_sent;
         while (blocks_sent - phase_start < ITEMS_PER_KEY) begin
            send_message();
            if (setting == PAUSE_SETTING && !paused &&
                blocks_sent - phase_start >= ITEMS_PER_KEY / 2) begin
               wait_for_results();
               paused = 1'b1;
            end
         end
         wait_for_results();
      end
      steady_stream = 1'b0;
      repeat (PIPE_LATENCY + 8) @(posedge clock);

      $display("Covered %0d encrypt and %0d decrypt requests, %0d flagged last, %0d checked,",
               encrypt_count, decrypt_count, last_count, checked_count);
      $display("under the reset key, %0d loaded keys, ignored key indexes and an output stall.",
               KEY_SETTINGS);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("simulation failed");
      $finish;
   end

endmodule

### tea_block_cipher_top.f
sv/tbc_pkg.sv
sv/tbc_req_if.sv
sv/tbc_rsp_if.sv
sv/tbc_key_regs.sv
sv/tbc_half_round.sv
sv/tea_block_cipher_top.sv
dv/tb_tea_block_cipher_top.sv
